@@ hdl/bna_pkg.sv @@
// types and constants shared by the bitmap number allocator
package bna_pkg;

    localparam int NUM_W = 12;
    localparam int CNT_W = 13;
    localparam int CFG_W = 7;

    localparam logic [CNT_W-1:0] CNT_MAX   = 13'd8191;
    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    localparam logic [1:0] ACT_ALLOC   = 2'd0;
    localparam logic [1:0] ACT_RELEASE = 2'd1;
    localparam logic [1:0] ACT_TEST    = 2'd2;
    localparam logic [1:0] ACT_NOP     = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [1:0]       action;
        logic [NUM_W-1:0] number;
    } in_item_t;

    typedef struct packed {
        logic [NUM_W-1:0] granted_number;
        logic             is_used;
        logic [1:0]       status;
        logic [CNT_W-1:0] in_use_count;
    } out_item_t;

endpackage

@@ hdl/bna_map_ram.sv @@
// usage bitmap memory, one write port and one registered read port
module bna_map_ram #(
    parameter int WORDS = 64,
    parameter int BITS  = 64,
    parameter int AW    = 6
) (
    input  logic            clk,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  logic [BITS-1:0] wr_data,
    input  logic            rd_en,
    input  logic [AW-1:0]   rd_addr,
    output logic [BITS-1:0] rd_data
);

    logic [BITS-1:0] mem [WORDS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ hdl/bna_num_split.sv @@
// splits a number into word index and bit position by reciprocal multiply
module bna_num_split #(
    parameter int WORD_BITS = 64
) (
    input  logic                        clk,
    input  logic                        load,
    input  logic [bna_pkg::NUM_W-1:0]   number,
    output logic [bna_pkg::NUM_W-1:0]   num,
    output logic [bna_pkg::NUM_W-1:0]   word,
    output logic [$clog2(WORD_BITS)-1:0] bit_pos
);

    localparam int NW    = bna_pkg::NUM_W;
    localparam int WB_W  = $clog2(WORD_BITS);
    localparam int SH    = 20;
    localparam int RECIP = (1 << SH) / WORD_BITS;
    localparam int PW    = NW + SH - 2;

    logic [PW-1:0] prod;
    logic [NW-1:0] num_reg;
    logic [NW-1:0] q_reg;
    logic [NW-1:0] q_times;
    logic [NW-1:0] rem;

    assign prod = PW'(number) * PW'(RECIP);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            num_reg <= number;
            q_reg   <= NW'(prod >> SH);
        end
    end

    // estimate may be one low, one correction step
    assign q_times = NW'(q_reg * NW'(WORD_BITS));
    assign rem     = num_reg - q_times;
    assign num     = num_reg;

    always_comb
    begin
        if (rem >= NW'(WORD_BITS))
        begin
            word    = q_reg + NW'(1);
            bit_pos = WB_W'(rem - NW'(WORD_BITS));
        end
        else
        begin
            word    = q_reg;
            bit_pos = WB_W'(rem);
        end
    end

endmodule

@@ hdl/bna_free_bit.sv @@
// lowest clear bit finder for one bitmap word
module bna_free_bit #(
    parameter int WORD_BITS = 64
) (
    input  logic [WORD_BITS-1:0]         data,
    output logic                         word_full,
    output logic [$clog2(WORD_BITS)-1:0] free_idx
);

    localparam int WB_W = $clog2(WORD_BITS);

    assign word_full = &data;

    always_comb
    begin
        free_idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (!data[i])
            begin
                free_idx = WB_W'(i);
            end
        end
    end

endmodule

@@ hdl/bitmap_number_allocator.sv @@
// bitmap number allocator top level: control sequencer, count and result register
// an item passes the split and eval states before the next acceptance when the hint word settles it
// an allocate whose hint word is full scans further words in the scan state, at most
// active words - 1 more; an out of range number or an unused action is settled in the split state
// the result is registered as the item is settled, or from the hold state once an output stall clears
// after reset the map memory is cleared one word per cycle, all MAP_WORDS words, with no request taken
module bitmap_number_allocator #(
    parameter int WORD_BITS = 64,
    parameter int MAP_WORDS = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  bna_pkg::in_item_t                   in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output bna_pkg::out_item_t                  out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bna_pkg::CFG_W-1:0]           cfg_data
);

    localparam int NW    = bna_pkg::NUM_W;
    localparam int CW    = bna_pkg::CNT_W;
    localparam int WB_W  = $clog2(WORD_BITS);
    localparam int MW_W  = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int NW_W  = ($clog2(MAP_WORDS + 1) > bna_pkg::CFG_W) ?
                           $clog2(MAP_WORDS + 1) : bna_pkg::CFG_W;
    localparam int LIM_W = NW_W + 8;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SPLIT = 3'd2;
    localparam logic [2:0] S_EVAL  = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;
    localparam logic [2:0] S_HOLD  = 3'd5;

    logic [2:0]                 state_reg, state_next;
    logic [bna_pkg::CFG_W-1:0]  active_reg;
    logic [CW-1:0]              count_reg, count_next;
    logic [1:0]                 act_reg, act_next;
    logic [MW_W-1:0]            word_reg, word_next;
    logic [NW_W-1:0]            scan_reg, scan_next;
    logic [MW_W-1:0]            clr_reg, clr_next;
    logic                       out_valid_reg;
    bna_pkg::out_item_t         out_data_reg;
    bna_pkg::out_item_t         hold_reg;

    logic                       split_load;
    logic [NW-1:0]              split_num;
    logic [NW-1:0]              split_word;
    logic [WB_W-1:0]            split_bit;

    logic                       wr_en;
    logic [MW_W-1:0]            wr_addr;
    logic [WORD_BITS-1:0]       wr_data;
    logic                       rd_en;
    logic [MW_W-1:0]            rd_addr;
    logic [WORD_BITS-1:0]       rd_data;

    logic                       word_full;
    logic [WB_W-1:0]            free_idx;

    logic [NW_W-1:0]            cfg_ext;
    logic [NW_W-1:0]            nw;
    logic [LIM_W-1:0]           limit;
    logic                       in_range;
    logic [WORD_BITS-1:0]       hint_mask;
    logic [WORD_BITS-1:0]       free_mask;
    logic [NW_W-1:0]            word_inc;
    logic [MW_W-1:0]            word_wrap;
    logic [NW-1:0]              grant_scan;
    logic [CW-1:0]              count_up;
    logic [CW-1:0]              count_dn;

    logic                       out_free;
    logic                       res_fire;
    logic                       out_load;
    bna_pkg::out_item_t         res;
    bna_pkg::out_item_t         out_src;

    bna_num_split #(
        .WORD_BITS (WORD_BITS)
    ) u_split (
        .clk     (clk),
        .load    (split_load),
        .number  (in_data.number),
        .num     (split_num),
        .word    (split_word),
        .bit_pos (split_bit)
    );

    bna_map_ram #(
        .WORDS (MAP_WORDS),
        .BITS  (WORD_BITS),
        .AW    (MW_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    bna_free_bit #(
        .WORD_BITS (WORD_BITS)
    ) u_free (
        .data      (rd_data),
        .word_full (word_full),
        .free_idx  (free_idx)
    );

    // effective word count, zero acts as one, values above MAP_WORDS clamp to MAP_WORDS
    assign cfg_ext = NW_W'(active_reg);
    always_comb
    begin
        if (cfg_ext == '0)
        begin
            nw = NW_W'(1);
        end
        else if (cfg_ext > NW_W'(MAP_WORDS))
        begin
            nw = NW_W'(MAP_WORDS);
        end
        else
        begin
            nw = cfg_ext;
        end
    end

    assign limit      = LIM_W'(nw) * LIM_W'(WORD_BITS);
    assign in_range   = LIM_W'(split_num) < limit;
    assign hint_mask  = WORD_BITS'(1) << split_bit;
    assign free_mask  = WORD_BITS'(1) << free_idx;
    assign word_inc   = NW_W'(word_reg) + NW_W'(1);
    assign word_wrap  = (word_inc == nw) ? '0 : MW_W'(word_inc);
    assign grant_scan = NW'(NW'(word_reg) * NW'(WORD_BITS)) + NW'(free_idx);
    assign count_up   = (count_reg != bna_pkg::CNT_MAX) ? count_reg + CW'(1) : count_reg;
    assign count_dn   = (count_reg != '0) ? count_reg - CW'(1) : count_reg;

    assign out_free   = !out_valid_reg || !out_stall;
    assign in_stall   = (state_reg != S_IDLE);
    assign cfg_ready  = 1'b1;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;
    assign split_load = (state_reg == S_IDLE) && in_valid;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        act_next   = act_reg;
        word_next  = word_reg;
        scan_next  = scan_reg;
        clr_next   = clr_reg;
        wr_en      = 1'b0;
        wr_addr    = word_reg;
        wr_data    = rd_data;
        rd_en      = 1'b0;
        rd_addr    = MW_W'(split_word);
        res_fire   = 1'b0;
        res.granted_number = '0;
        res.is_used        = 1'b0;
        res.status         = bna_pkg::ST_OK;
        res.in_use_count   = count_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                wr_data  = '0;
                clr_next = clr_reg + MW_W'(1);
                if (clr_reg == MW_W'(MAP_WORDS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    act_next   = in_data.action;
                    state_next = S_SPLIT;
                end
            end
            S_SPLIT:
            begin
                if (act_reg == bna_pkg::ACT_NOP)
                begin
                    res_fire = 1'b1;
                end
                else if (!in_range)
                begin
                    res.status = bna_pkg::ST_RANGE;
                    res_fire   = 1'b1;
                end
                else
                begin
                    rd_en      = 1'b1;
                    word_next  = MW_W'(split_word);
                    scan_next  = '0;
                    state_next = S_EVAL;
                end
            end
            S_EVAL, S_SCAN:
            begin
                case (act_reg)
                    bna_pkg::ACT_TEST:
                    begin
                        res.is_used = rd_data[split_bit];
                        res_fire    = 1'b1;
                    end
                    bna_pkg::ACT_RELEASE:
                    begin
                        wr_en      = 1'b1;
                        wr_data    = rd_data & ~hint_mask;
                        count_next = count_dn;
                        res_fire   = 1'b1;
                    end
                    bna_pkg::ACT_ALLOC:
                    begin
                        if (state_reg == S_EVAL && !rd_data[split_bit])
                        begin
                            wr_en              = 1'b1;
                            wr_data            = rd_data | hint_mask;
                            count_next         = count_up;
                            res.granted_number = split_num;
                            res_fire           = 1'b1;
                        end
                        else if (!word_full)
                        begin
                            wr_en              = 1'b1;
                            wr_data            = rd_data | free_mask;
                            count_next         = count_up;
                            res.granted_number = grant_scan;
                            res_fire           = 1'b1;
                        end
                        else if (scan_reg + NW_W'(1) == nw)
                        begin
                            res.status = bna_pkg::ST_FULL;
                            res_fire   = 1'b1;
                        end
                        else
                        begin
                            word_next  = word_wrap;
                            scan_next  = scan_reg + NW_W'(1);
                            rd_en      = 1'b1;
                            rd_addr    = word_wrap;
                            state_next = S_SCAN;
                        end
                    end
                    default:
                    begin
                        res_fire = 1'b1;
                    end
                endcase
                res.in_use_count = count_next;
            end
            S_HOLD:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (res_fire)
        begin
            state_next = out_free ? S_IDLE : S_HOLD;
        end
    end

    assign out_load = (res_fire || (state_reg == S_HOLD)) && out_free;
    assign out_src  = (state_reg == S_HOLD) ? hold_reg : res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            active_reg    <= bna_pkg::CFG_RESET;
            count_reg     <= '0;
            act_reg       <= bna_pkg::ACT_NOP;
            word_reg      <= '0;
            scan_reg      <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            act_reg    <= act_next;
            word_reg   <= word_next;
            scan_reg   <= scan_next;
            clr_reg    <= clr_next;
            if (cfg_valid && cfg_ready)
            begin
                active_reg <= cfg_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= out_src;
        end
        if (res_fire && !out_free)
        begin
            hold_reg <= res;
        end
    end

    // count moves by at most one per request
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            (count_reg == $past(count_reg) + CW'(1) || count_reg == $past(count_reg) - CW'(1)))
        else $error("use count jumped");

    // a word scan never runs past the active words
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (scan_reg < nw))
        else $error("scan passed active words");

    // map full only reported by an allocate at the end of a scan
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_fire && res.status == bna_pkg::ST_FULL) |->
            (act_reg == bna_pkg::ACT_ALLOC && (state_reg == S_EVAL || state_reg == S_SCAN)))
        else $error("full reported outside allocate");

    // no request taken while a result is parked
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_HOLD) |=> (state_reg == S_HOLD || state_reg == S_IDLE) && out_valid_reg)
        else $error("parked result lost");

endmodule

@@ tb/sv/bna_checker.sv @@
// result checker for the bitmap number allocator: mirrors the map and compares every result
`timescale 1ns / 100ps

module bna_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_stall,
    input  bna_pkg::in_item_t         in_data,
    input  logic                      out_valid,
    input  logic                      out_stall,
    input  bna_pkg::out_item_t        out_data,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [bna_pkg::CFG_W-1:0] cfg_data,
    output int                        outstanding,
    output int                        fail_count
);

    localparam int BITS_PER_WORD = 64;
    localparam int WORDS_IN_MAP  = 64;

    logic [BITS_PER_WORD-1:0]  usage_map [WORDS_IN_MAP];
    logic [bna_pkg::CNT_W-1:0] in_use_total;
    logic [bna_pkg::CFG_W-1:0] active_words_reg;
    bna_pkg::out_item_t        expected_results [$];
    int                        result_index;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        fail_count++;
    endtask

    function automatic int words_in_use();
        if (active_words_reg == 0)
            return 1;
        if (active_words_reg > WORDS_IN_MAP)
            return WORDS_IN_MAP;
        return int'(active_words_reg);
    endfunction

    function automatic void take_bit(input int w, input int b, inout bna_pkg::out_item_t r);
        usage_map[w][b] = 1'b1;
        if (in_use_total != bna_pkg::CNT_MAX)
            in_use_total++;
        r.granted_number = bna_pkg::NUM_W'(w * BITS_PER_WORD + b);
    endfunction

    function automatic bna_pkg::out_item_t compute_outcome(input bna_pkg::in_item_t req);
        bna_pkg::out_item_t r;
        int                 nw;
        int                 num;
        int                 w;
        int                 b;
        int                 c;
        bit                 found;
        r     = '0;
        nw    = words_in_use();
        num   = int'(req.number);
        w     = num / BITS_PER_WORD;
        b     = num % BITS_PER_WORD;
        found = 1'b0;
        if (req.action != bna_pkg::ACT_NOP && num >= nw * BITS_PER_WORD) begin
            r.status = bna_pkg::ST_RANGE;
        end
        else if (req.action == bna_pkg::ACT_ALLOC) begin
            if (!usage_map[w][b]) begin
                take_bit(w, b, r);
            end
            else begin
                // scan from the hint word, wrapping over the active words
                for (c = 0; c < nw && !found; c++) begin
                    if (usage_map[w] != '1)
                        found = 1'b1;
                    else
                        w = (w + 1) % nw;
                end
                if (found) begin
                    b = 0;
                    while (usage_map[w][b])
                        b++;
                    take_bit(w, b, r);
                end
                else begin
                    r.status = bna_pkg::ST_FULL;
                end
            end
        end
        else if (req.action == bna_pkg::ACT_RELEASE) begin
            usage_map[w][b] = 1'b0;
            if (in_use_total != 0)
                in_use_total--;
        end
        else if (req.action == bna_pkg::ACT_TEST) begin
            r.is_used = usage_map[w][b];
        end
        r.in_use_count = in_use_total;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        bna_pkg::out_item_t exp_item;
        if (!rst_n) begin
            foreach (usage_map[i])
                usage_map[i] = '0;
            in_use_total     = '0;
            active_words_reg = bna_pkg::CFG_RESET;
            expected_results.delete();
            result_index     = 0;
            outstanding      <= 0;
            fail_count       = 0;
        end
        else begin
            if (cfg_valid && cfg_ready)
                active_words_reg = cfg_data;
            if (in_valid && !in_stall)
                expected_results.push_back(compute_outcome(in_data));
            if (out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with no request pending",
                                              result_index));
                end
                else begin
                    exp_item = expected_results.pop_front();
                    if (out_data !== exp_item)
                        report_mismatch($sformatf({"result %0d: got grant %0d used %0b",
                            " status %0d count %0d, expected grant %0d used %0b",
                            " status %0d count %0d"},
                            result_index, out_data.granted_number, out_data.is_used,
                            out_data.status, out_data.in_use_count, exp_item.granted_number,
                            exp_item.is_used, exp_item.status, exp_item.in_use_count));
                end
                result_index++;
            end
            outstanding <= expected_results.size();
        end
    end

endmodule

@@ tb/sv/tb_bitmap_number_allocator.sv @@
// testbench top for the bitmap number allocator: stimulus, idling and verdict
`timescale 1ns / 100ps

module tb_bitmap_number_allocator;

    localparam int CYCLE_LIMIT = 1000000;

    logic                       clk;
    logic                       rst_n      = 1'b0;
    logic                       in_valid   = 1'b0;
    logic                       in_stall;
    bna_pkg::in_item_t          in_data    = '0;
    logic                       out_valid;
    logic                       out_stall  = 1'b0;
    bna_pkg::out_item_t         out_data;
    logic                       cfg_valid  = 1'b0;
    logic                       cfg_ready;
    logic [bna_pkg::CFG_W-1:0]  cfg_data   = '0;

    int                 outstanding;
    int                 fail_count;
    int                 snd_idle_pct  = 26;
    int                 rcv_stall_pct = 55;
    int                 number_limit  = 4096;
    int                 cycle_count   = 0;

    bitmap_number_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    bna_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .outstanding (outstanding),
        .fail_count  (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < rcv_stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("** bitmap_number_allocator: FAILED **");
            $finish;
        end
    end

    function automatic bna_pkg::in_item_t make_request(input logic [1:0] act, input int num);
        bna_pkg::in_item_t r;
        r.action = act;
        r.number = bna_pkg::NUM_W'(num);
        return r;
    endfunction

    task automatic send_request(input bna_pkg::in_item_t req);
        if ($urandom_range(99) < snd_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < snd_idle_pct);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic write_active_words(input logic [bna_pkg::CFG_W-1:0] value);
        int eff;
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        eff = (value == 0) ? 1 : ((value > 64) ? 64 : int'(value));
        number_limit = eff * 64;
    endtask

    function automatic bna_pkg::in_item_t random_request(input int alloc_pct);
        int r;
        int num;
        logic [1:0] act;
        r = $urandom_range(99);
        if (r < alloc_pct)
            act = bna_pkg::ACT_ALLOC;
        else if (r < alloc_pct + (100 - alloc_pct) * 55 / 100)
            act = bna_pkg::ACT_RELEASE;
        else if (r < 96)
            act = bna_pkg::ACT_TEST;
        else
            act = bna_pkg::ACT_NOP;
        if (number_limit < 4096 && $urandom_range(99) < 6)
            num = $urandom_range(4095, number_limit);
        else
            num = $urandom_range(number_limit - 1, 0);
        return make_request(act, num);
    endfunction

    task automatic run_section(input logic [bna_pkg::CFG_W-1:0] value, input int count,
                               input int alloc_pct);
        write_active_words(value);
        repeat (count) begin
            // occasionally let the block run dry before the next request
            if ($urandom_range(99) == 0)
                drain_results();
            send_request(random_request(alloc_pct));
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(make_request(bna_pkg::ACT_TEST, 0));
        send_request(make_request(bna_pkg::ACT_ALLOC, 0));
        send_request(make_request(bna_pkg::ACT_ALLOC, 0));
        send_request(make_request(bna_pkg::ACT_ALLOC, 4095));
        send_request(make_request(bna_pkg::ACT_TEST, 4095));
        send_request(make_request(bna_pkg::ACT_TEST, 1));
        send_request(make_request(bna_pkg::ACT_RELEASE, 0));
        send_request(make_request(bna_pkg::ACT_RELEASE, 0));
        send_request(make_request(bna_pkg::ACT_RELEASE, 4095));
        send_request(make_request(bna_pkg::ACT_RELEASE, 5));
        send_request(make_request(bna_pkg::ACT_NOP, 4095));
        send_request(make_request(bna_pkg::ACT_NOP, 0));
        write_active_words(7'd1);
        send_request(make_request(bna_pkg::ACT_ALLOC, 64));
        send_request(make_request(bna_pkg::ACT_TEST, 4095));
        send_request(make_request(bna_pkg::ACT_RELEASE, 100));
        send_request(make_request(bna_pkg::ACT_NOP, 4095));
        send_request(make_request(bna_pkg::ACT_ALLOC, 1));

        // zero acts as one word, so the map fills quickly
        run_section(7'd0, 150, 80);
        run_section(7'd2, 200, 75);
        run_section(7'd64, 250, 60);

        drain_results();
        snd_idle_pct  = 55;
        rcv_stall_pct = 26;
        run_section(7'd127, 200, 55);
        run_section(7'd5, 250, 80);
        run_section(7'd1, 150, 50);

        drain_results();
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        run_section(7'd3, 250, 75);
        run_section(7'd100, 200, 55);

        drain_results();
        repeat (80) @(posedge clk);
        if (fail_count == 0)
            $display("** bitmap_number_allocator: PASSED **");
        else
            $display("** bitmap_number_allocator: FAILED **");
        $finish;
    end

endmodule
